@@ rtl/splc_pkg.sv @@
// Shared types and constants for the piecewise linear sensor correction block.
// Depends on nothing; every other file in rtl/ but splc_ram refers to it by scoped names.

package splc_pkg;

	// configuration port
	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W  = 32;
	localparam int NUM_REGS    = 8;
	localparam int REG_ADDR_W  = 3;
	localparam logic [CFG_INDEX_W-1:0] REG_HUMI_TOP = 4'd7;

	// knot layout: temperature entries 0..8, humidity entries 9..14
	localparam int TEMP_KNOTS = 9;
	localparam int HUMI_KNOTS = 6;
	localparam int MAX_SEG    = TEMP_KNOTS - 2;
	localparam int ENTRY_W    = 4;
	localparam logic [ENTRY_W-1:0] TEMP_FIRST = 4'd0;
	localparam logic [ENTRY_W-1:0] HUMI_FIRST = 4'd9;

	// reading ranges and special values, hundredths
	localparam logic signed [15:0] TEMP_LOW   = -16'sd4000;
	localparam logic signed [15:0] TEMP_HIGH  = 16'sd12000;
	localparam logic signed [15:0] HUMI_LOW   = 16'sd0;
	localparam logic signed [15:0] HUMI_LIMIT = 16'sd10000;
	localparam logic signed [15:0] OOR_VALUE  = -16'sd20000;
	localparam logic signed [15:0] SAT_MAX    = 16'sh7FFF;
	localparam logic signed [15:0] SAT_MIN    = 16'sh8000;

	// datapath widths that do not depend on the segment span
	localparam int READ_W  = 16;
	localparam int OFF_W   = 16;
	localparam int IDX_W   = 3;
	localparam int DELTA_W = 15;  // offset into a segment, at most 16000
	localparam int SUM_W   = 17;  // reading plus one knot offset
	localparam int DIFF_W  = 17;  // difference of two knot offsets
	localparam int PROD_W  = 32;  // delta times offset difference

	// magnitude bounds of the in-range numerator terms
	localparam longint SUM_MAX  = 44767;        // 12000 + 32767
	localparam longint PROD_MAX = 1048560000;   // 16000 * 65535

	typedef struct packed {
		logic                     oor;
		logic signed [READ_W-1:0] x;
		logic [DELTA_W-1:0]       delta;
		logic                     odd;    // low knot sits in the upper half of its word
	} seg_t;

	// bits needed for |(x + off_lo) * span + delta * (off_hi - off_lo)|
	function automatic int mag_width(input int span);
		longint bound;
		bound = SUM_MAX * longint'(span) + PROD_MAX;
		return $clog2(bound + 64'sd1);
	endfunction

endpackage

@@ rtl/splc_ram.sv @@
// Generic single-write, dual-read RAM with registered read data.
// Stands alone; holds the knot offset words for the correction block.

module splc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr0,
	input  logic [$clog2(DEPTH)-1:0] raddr1,
	output logic [WIDTH-1:0]         rdata0,
	output logic [WIDTH-1:0]         rdata1
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata0 <= mem[raddr0];
			rdata1 <= mem[raddr1];
		end
	end

endmodule

@@ rtl/splc_locate.sv @@
// Range check and segment search for one reading, ending in the first stage register.
// Uses splc_pkg; drives the knot RAM read addresses.

module splc_locate #(
	parameter int SEGMENT_SPAN = 2000
) (
	input  logic                                clk,
	input  logic                                en,
	input  logic                                kind,
	input  logic signed [splc_pkg::READ_W-1:0]  reading,
	output logic [splc_pkg::REG_ADDR_W-1:0]     addr_lo,
	output logic [splc_pkg::REG_ADDR_W-1:0]     addr_hi,
	output splc_pkg::seg_t                      seg_s1
);

	localparam int POS_W = $clog2(splc_pkg::MAX_SEG * SEGMENT_SPAN + 1);

	logic                                oor;
	logic signed [splc_pkg::READ_W-1:0]  low;
	logic signed [splc_pkg::READ_W:0]    rel;
	logic [splc_pkg::DELTA_W-1:0]        rel_u;
	logic [splc_pkg::IDX_W-1:0]          cap;
	logic [splc_pkg::IDX_W-1:0]          idx;
	logic [POS_W-1:0]                    pos;
	logic [splc_pkg::DELTA_W-1:0]        delta;
	logic [splc_pkg::ENTRY_W-1:0]        entry;
	logic [splc_pkg::ENTRY_W-1:0]        entry_nx;

	always_comb begin
		if (kind) begin
			oor = (reading < splc_pkg::HUMI_LOW) || (reading >= splc_pkg::HUMI_LIMIT);
			low = splc_pkg::HUMI_LOW;
			cap = splc_pkg::IDX_W'(splc_pkg::HUMI_KNOTS - 2);
		end else begin
			oor = (reading < splc_pkg::TEMP_LOW) || (reading > splc_pkg::TEMP_HIGH);
			low = splc_pkg::TEMP_LOW;
			cap = splc_pkg::IDX_W'(splc_pkg::TEMP_KNOTS - 2);
		end
		rel   = {reading[splc_pkg::READ_W-1], reading} - {low[splc_pkg::READ_W-1], low};
		rel_u = rel[splc_pkg::DELTA_W-1:0];

		// boundaries are constants; the last match wins, clamped to the top segment
		idx = '0;
		pos = '0;
		for (int j = 1; j <= splc_pkg::MAX_SEG; j++) begin
			if (splc_pkg::IDX_W'(j) <= cap && 32'(rel_u) >= 32'(j * SEGMENT_SPAN)) begin
				idx = splc_pkg::IDX_W'(j);
				pos = POS_W'(j * SEGMENT_SPAN);
			end
		end
		delta = splc_pkg::DELTA_W'(32'(rel_u) - 32'(pos));

		entry    = (kind ? splc_pkg::HUMI_FIRST : splc_pkg::TEMP_FIRST)
			+ {{(splc_pkg::ENTRY_W - splc_pkg::IDX_W){1'b0}}, idx};
		entry_nx = entry + splc_pkg::ENTRY_W'(1);
	end

	// two offsets per configuration word
	assign addr_lo = entry[splc_pkg::ENTRY_W-1:1];
	assign addr_hi = entry_nx[splc_pkg::ENTRY_W-1:1];

	always_ff @(posedge clk) begin
		if (en) begin
			seg_s1.oor   <= oor;
			seg_s1.x     <= reading;
			seg_s1.delta <= delta;
			seg_s1.odd   <= entry[0];
		end
	end

endmodule

@@ rtl/splc_interp.sv @@
// Interpolation numerator: knot offset pick, both products, then sum and magnitude.
// Uses splc_pkg; fed by splc_locate and the knot RAM, feeds splc_recip_div.

module splc_interp #(
	parameter int SEGMENT_SPAN = 2000
) (
	input  logic                                   clk,
	input  logic                                   en,
	input  splc_pkg::seg_t                         seg_s1,
	input  logic [splc_pkg::CFG_DATA_W-1:0]        lo_word,
	input  logic [splc_pkg::CFG_DATA_W-1:0]        hi_word,
	output logic                                   oor_s3,
	output logic                                   neg_s3,
	output logic [splc_pkg::mag_width(SEGMENT_SPAN)-1:0] mag_s3
);

	localparam int SPAN_W = $clog2(SEGMENT_SPAN + 1);
	localparam int AS_W   = splc_pkg::SUM_W + SPAN_W + 1;
	localparam int NUM_W  = ((AS_W > splc_pkg::PROD_W) ? AS_W : splc_pkg::PROD_W) + 1;
	localparam int MAG_W  = splc_pkg::mag_width(SEGMENT_SPAN);
	localparam logic signed [SPAN_W:0] SPAN_S = (SPAN_W + 1)'(SEGMENT_SPAN);

	logic [splc_pkg::OFF_W-1:0]          off_lo;
	logic [splc_pkg::OFF_W-1:0]          off_hi;
	logic signed [splc_pkg::SUM_W-1:0]   sum;
	logic signed [splc_pkg::DIFF_W-1:0]  diff;
	logic signed [splc_pkg::PROD_W-1:0]  prod;
	logic signed [AS_W-1:0]              scaled;

	logic                                oor_s2;
	logic signed [splc_pkg::PROD_W-1:0]  prod_s2;
	logic signed [AS_W-1:0]              scaled_s2;

	logic signed [NUM_W-1:0]             num;
	logic signed [NUM_W-1:0]             num_abs;

	// num = (x + off_lo) * span + delta * (off_hi - off_lo), since knot_lo + delta = x + off_lo
	always_comb begin
		if (seg_s1.odd) begin
			off_lo = lo_word[31:16];
			off_hi = hi_word[15:0];
		end else begin
			off_lo = lo_word[15:0];
			off_hi = hi_word[31:16];
		end
		sum    = {seg_s1.x[splc_pkg::READ_W-1], seg_s1.x} + {off_lo[splc_pkg::OFF_W-1], off_lo};
		diff   = {off_hi[splc_pkg::OFF_W-1], off_hi} - {off_lo[splc_pkg::OFF_W-1], off_lo};
		prod   = splc_pkg::PROD_W'($signed({1'b0, seg_s1.delta})) * splc_pkg::PROD_W'(diff);
		scaled = AS_W'(sum) * AS_W'(SPAN_S);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			oor_s2    <= seg_s1.oor;
			prod_s2   <= prod;
			scaled_s2 <= scaled;
		end
	end

	always_comb begin
		num     = NUM_W'(scaled_s2) + NUM_W'(prod_s2);
		num_abs = num[NUM_W-1] ? -num : num;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			oor_s3 <= oor_s2;
			neg_s3 <= num[NUM_W-1];
			mag_s3 <= num_abs[MAG_W-1:0];
		end
	end

endmodule

@@ rtl/splc_recip_div.sv @@
// Exact division of the numerator magnitude by the segment span, sign restore, saturation and out-of-range value.
// Uses splc_pkg; fed by splc_interp, holds the result register.

module splc_recip_div #(
	parameter int SEGMENT_SPAN = 2000
) (
	input  logic                                         clk,
	input  logic                                         en,
	input  logic                                         oor_s3,
	input  logic                                         neg_s3,
	input  logic [splc_pkg::mag_width(SEGMENT_SPAN)-1:0] mag_s3,
	output logic signed [splc_pkg::READ_W-1:0]           corrected_q,
	output logic                                         oor_q
);

	localparam int MAG_W = splc_pkg::mag_width(SEGMENT_SPAN);
	localparam int SHIFT = MAG_W + $clog2(SEGMENT_SPAN);
	// ceil(2^SHIFT / span): floor of the scaled product is exact for any magnitude below 2^MAG_W
	localparam longint unsigned RECIP =
		((64'd1 << SHIFT) + 64'(SEGMENT_SPAN) - 64'd1) / 64'(SEGMENT_SPAN);
	localparam logic [MAG_W:0] RECIP_V = (MAG_W + 1)'(RECIP);

	logic [2*MAG_W:0]                 prod;
	logic [MAG_W-1:0]                 quo;
	logic signed [splc_pkg::READ_W-1:0] res;

	always_comb begin
		prod = (2 * MAG_W + 1)'(mag_s3) * (2 * MAG_W + 1)'(RECIP_V);
		quo  = MAG_W'(prod >> SHIFT);
		if (oor_s3) begin
			res = splc_pkg::OOR_VALUE;
		end else if (!neg_s3 && quo > MAG_W'(32767)) begin
			res = splc_pkg::SAT_MAX;
		end else if (neg_s3 && quo > MAG_W'(32768)) begin
			res = splc_pkg::SAT_MIN;
		end else if (neg_s3) begin
			res = -$signed(quo[splc_pkg::READ_W-1:0]);
		end else begin
			res = $signed(quo[splc_pkg::READ_W-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			corrected_q <= res;
			oor_q       <= oor_s3;
		end
	end

endmodule

@@ rtl/sensor_piecewise_linear_correction.sv @@
// Piecewise linear sensor correction, top level: configuration, knot store, pipeline control.
// Uses splc_pkg, splc_ram, splc_locate, splc_interp and splc_recip_div.
//
// One reading is taken per clock while ready is high, and its corrected value appears on the
// result channel after four register stages (segment search with knot RAM read, the two
// products, the signed numerator sum, and the reciprocal multiply that divides by the segment
// span); all four advance together, so the throughput is one item per cycle while
// result_ready is high and the whole pipeline holds while a result waits. Knot offsets live in
// an eight-word RAM written through the cfg channel (always ready); a word never written reads
// as zero through a per-word written flag, so no clearing pass follows reset.

module sensor_piecewise_linear_correction #(
	parameter int SEGMENT_SPAN = 2000
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 valid,
	output logic                                 ready,
	input  logic                                 kind,
	input  logic signed [splc_pkg::READ_W-1:0]   reading,
	output logic                                 result_valid,
	input  logic                                 result_ready,
	output logic signed [splc_pkg::READ_W-1:0]   corrected,
	output logic                                 out_of_range,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [splc_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [splc_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int MAG_W = splc_pkg::mag_width(SEGMENT_SPAN);

	logic                                en;
	logic                                v1_q;
	logic                                v2_q;
	logic                                v3_q;
	logic                                out_valid_q;

	logic                                cfg_we;
	logic [splc_pkg::REG_ADDR_W-1:0]     cfg_addr;
	logic [splc_pkg::CFG_DATA_W-1:0]     cfg_wdata;
	logic [splc_pkg::NUM_REGS-1:0]       written_q;

	logic [splc_pkg::REG_ADDR_W-1:0]     addr_lo;
	logic [splc_pkg::REG_ADDR_W-1:0]     addr_hi;
	logic [splc_pkg::CFG_DATA_W-1:0]     ram_lo;
	logic [splc_pkg::CFG_DATA_W-1:0]     ram_hi;
	logic                                lo_written_s1;
	logic                                hi_written_s1;
	logic [splc_pkg::CFG_DATA_W-1:0]     lo_word;
	logic [splc_pkg::CFG_DATA_W-1:0]     hi_word;

	splc_pkg::seg_t                      seg_s1;
	logic                                oor_s3;
	logic                                neg_s3;
	logic [MAG_W-1:0]                    mag_s3;

	// whole pipeline moves unless a finished result is stalled
	assign en           = !out_valid_q || result_ready;
	assign ready        = en;
	assign result_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q        <= 1'b0;
			v2_q        <= 1'b0;
			v3_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v1_q        <= valid;
			v2_q        <= v1_q;
			v3_q        <= v2_q;
			out_valid_q <= v3_q;
		end
	end

	// configuration: indexes past the list are dropped, the last register is 16 bits
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && (cfg_index < splc_pkg::CFG_INDEX_W'(splc_pkg::NUM_REGS));
	assign cfg_addr  = cfg_index[splc_pkg::REG_ADDR_W-1:0];
	assign cfg_wdata = (cfg_index == splc_pkg::REG_HUMI_TOP) ? {16'd0, cfg_data[15:0]} : cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (cfg_we) begin
			written_q[cfg_addr] <= 1'b1;
		end
	end

	splc_ram #(
		.WIDTH (splc_pkg::CFG_DATA_W),
		.DEPTH (splc_pkg::NUM_REGS)
	) u_knots (
		.clk    (clk),
		.we     (cfg_we),
		.waddr  (cfg_addr),
		.wdata  (cfg_wdata),
		.re     (en),
		.raddr0 (addr_lo),
		.raddr1 (addr_hi),
		.rdata0 (ram_lo),
		.rdata1 (ram_hi)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			lo_written_s1 <= written_q[addr_lo];
			hi_written_s1 <= written_q[addr_hi];
		end
	end

	assign lo_word = lo_written_s1 ? ram_lo : '0;
	assign hi_word = hi_written_s1 ? ram_hi : '0;

	splc_locate #(
		.SEGMENT_SPAN (SEGMENT_SPAN)
	) u_locate (
		.clk     (clk),
		.en      (en),
		.kind    (kind),
		.reading (reading),
		.addr_lo (addr_lo),
		.addr_hi (addr_hi),
		.seg_s1  (seg_s1)
	);

	splc_interp #(
		.SEGMENT_SPAN (SEGMENT_SPAN)
	) u_interp (
		.clk     (clk),
		.en      (en),
		.seg_s1  (seg_s1),
		.lo_word (lo_word),
		.hi_word (hi_word),
		.oor_s3  (oor_s3),
		.neg_s3  (neg_s3),
		.mag_s3  (mag_s3)
	);

	splc_recip_div #(
		.SEGMENT_SPAN (SEGMENT_SPAN)
	) u_div (
		.clk         (clk),
		.en          (en),
		.oor_s3      (oor_s3),
		.neg_s3      (neg_s3),
		.mag_s3      (mag_s3),
		.corrected_q (corrected),
		.oor_q       (out_of_range)
	);

	a_oor_value: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && out_of_range |-> corrected == splc_pkg::OOR_VALUE)
		else $error("out-of-range result without the out-of-range value");

	a_last_stage_moves: assert property (@(posedge clk) disable iff (!arst_n)
		en && v3_q |=> result_valid)
		else $error("last pipeline stage did not reach the result register");

	a_written_flag: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> written_q[$past(cfg_addr)])
		else $error("configuration write did not mark its word as written");

endmodule
